### rtl/vtx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtx_pkg
// Shared widths, register map and reset matrix of the 4x4 vertex transform.
// ----------------------------------------------------------------------------
package vtx_pkg;

  // Fixed-point format of vector components and matrix elements
  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NUM_COMP  = 4;

  // Full-width product and exact sums of two and four products
  localparam int PROD_W = 2 * DATA_W;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  // Configuration register map: eight 64-bit registers at byte address 8*i
  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 2 * DATA_W;
  localparam int REG_LSB    = 3;
  localparam int IDX_W      = $clog2(NUM_REGS);
  localparam int ADDR_W     = IDX_W + REG_LSB;

  // Stream payload widths
  localparam int VEC_W = NUM_COMP * DATA_W;

  // Fixed-point one
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  // Saturation limits
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Identity matrix at reset
  localparam logic [REG_W-1:0] MAT_RESET [NUM_REGS] = '{
    {{DATA_W{1'b0}}, ONE},
    {REG_W{1'b0}},
    {ONE, {DATA_W{1'b0}}},
    {REG_W{1'b0}},
    {REG_W{1'b0}},
    {{DATA_W{1'b0}}, ONE},
    {REG_W{1'b0}},
    {ONE, {DATA_W{1'b0}}}
  };

endpackage

### rtl/vertex_transform_4x4_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_4x4_unit
// Q16.16 homogeneous 4-vector times 4x4 matrix, five register stages.
// ----------------------------------------------------------------------------
// An item passes the vector, product, pair, column-sum and output registers.
// Throughput: one item per cycle unless m_axis stalls; the sixteen 32x32
// multipliers of the product and two adder stages set the pipeline depth.
// Back-pressure stalls full stages with no empty stage after them; gaps fill.
// Reset (rst, synchronous) empties the pipeline and loads the identity matrix.
// ----------------------------------------------------------------------------
module vertex_transform_4x4_unit (
  input  logic                           clk,
  input  logic                           rst,
  // input item stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: vec_x, vec_y, vec_z, vec_w
  input  logic [vtx_pkg::VEC_W-1:0]      s_axis_tdata,
  // tuser: point_mode
  input  logic                           s_axis_tuser,
  // result item stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, low bit up: out_x, out_y, out_z, out_w
  output logic [vtx_pkg::VEC_W-1:0]      m_axis_tdata,
  // tuser: saturated
  output logic                           m_axis_tuser,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [vtx_pkg::ADDR_W-1:0]     paddr,
  input  logic [vtx_pkg::REG_W-1:0]      pwdata,
  output logic [vtx_pkg::REG_W-1:0]      prdata,
  output logic                           pready
);

  localparam int DW = vtx_pkg::DATA_W;
  localparam int NC = vtx_pkg::NUM_COMP;

  // --------------------------------------------------------------------------
  // Matrix registers
  // --------------------------------------------------------------------------
  logic [vtx_pkg::REG_W-1:0] mat [vtx_pkg::NUM_REGS];
  logic [vtx_pkg::IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[vtx_pkg::ADDR_W-1:vtx_pkg::REG_LSB];
  assign pready  = 1'b1;
  assign prdata  = mat[reg_idx];

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= vtx_pkg::MAT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      mat[reg_idx] <= pwdata;
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or its successor loads
  // --------------------------------------------------------------------------
  logic vld1, vld2, vld3, vld4, vld5;
  logic en1, en2, en3, en4, en5;

  assign en5 = !vld5 || m_axis_tready;
  assign en4 = !vld4 || en5;
  assign en3 = !vld3 || en4;
  assign en2 = !vld2 || en3;
  assign en1 = !vld1 || en2;

  assign s_axis_tready = en1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
      vld2 <= 1'b0;
      vld3 <= 1'b0;
      vld4 <= 1'b0;
      vld5 <= 1'b0;
    end else begin
      if (en1) vld1 <= s_axis_tvalid;
      if (en2) vld2 <= vld1;
      if (en3) vld3 <= vld2;
      if (en4) vld4 <= vld3;
      if (en5) vld5 <= vld4;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: register the vector, w forced to one in point mode
  // --------------------------------------------------------------------------
  logic signed [DW-1:0] vec1 [NC];

  always_ff @(posedge clk) begin
    if (en1) begin
      vec1[0] <= s_axis_tdata[0*DW +: DW];
      vec1[1] <= s_axis_tdata[1*DW +: DW];
      vec1[2] <= s_axis_tdata[2*DW +: DW];
      vec1[3] <= s_axis_tuser ? vtx_pkg::ONE : s_axis_tdata[3*DW +: DW];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: sixteen full-width products, prod2[i][j] = M[i][j] * v[i]
  // Stage 3: pair sums per column, rows 0+1 and rows 2+3
  // Stage 4: column sums
  // --------------------------------------------------------------------------
  logic signed [vtx_pkg::PROD_W-1:0] prod2 [NC][NC];
  logic signed [vtx_pkg::PAIR_W-1:0] pair3 [2][NC];
  logic signed [vtx_pkg::SUM_W-1:0]  sum4  [NC];

  for (genvar gj = 0; gj < NC; gj++) begin : g_col
    for (genvar gi = 0; gi < NC; gi++) begin : g_row
      localparam int RIDX = 2 * gi + (gj >> 1);
      localparam int HALF = (gj & 1) * DW;
      logic signed [DW-1:0] elem;

      assign elem = mat[RIDX][HALF +: DW];

      // Multiply
      always_ff @(posedge clk) begin
        if (en2) begin
          prod2[gi][gj] <= vtx_pkg::PROD_W'(elem) * vtx_pkg::PROD_W'(vec1[gi]);
        end
      end
    end

    // Add row pairs
    always_ff @(posedge clk) begin
      if (en3) begin
        pair3[0][gj] <= vtx_pkg::PAIR_W'(prod2[0][gj]) + vtx_pkg::PAIR_W'(prod2[1][gj]);
        pair3[1][gj] <= vtx_pkg::PAIR_W'(prod2[2][gj]) + vtx_pkg::PAIR_W'(prod2[3][gj]);
      end
    end

    // Add the two pairs
    always_ff @(posedge clk) begin
      if (en4) begin
        sum4[gj] <= vtx_pkg::SUM_W'(pair3[0][gj]) + vtx_pkg::SUM_W'(pair3[1][gj]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: drop the fraction (floor) and clamp to 32 bits
  // --------------------------------------------------------------------------
  logic signed [vtx_pkg::SUM_W-1:0] shifted [NC];
  logic        [DW-1:0]             clamp   [NC];
  logic        [NC-1:0]             ovf;

  always_comb begin
    for (int j = 0; j < NC; j++) begin
      shifted[j] = sum4[j] >>> vtx_pkg::FRAC_BITS;
      ovf[j]     = !((&shifted[j][vtx_pkg::SUM_W-1:DW-1]) ||
                     !(|shifted[j][vtx_pkg::SUM_W-1:DW-1]));
      if (!ovf[j]) begin
        clamp[j] = shifted[j][DW-1:0];
      end else if (shifted[j][vtx_pkg::SUM_W-1]) begin
        clamp[j] = vtx_pkg::SAT_MIN;
      end else begin
        clamp[j] = vtx_pkg::SAT_MAX;
      end
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (en5) begin
      m_axis_tdata <= {clamp[3], clamp[2], clamp[1], clamp[0]};
      m_axis_tuser <= |ovf;
    end
  end

  assign m_axis_tvalid = vld5;

endmodule

### rtl/vtx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtx_checker
// Port-level checks of the vertex transform: hold, reset, flow, phantom results, clamping.
// ----------------------------------------------------------------------------
module vtx_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [vtx_pkg::VEC_W-1:0]  m_axis_tdata,
  input logic                       m_axis_tuser
);

  localparam int DW = vtx_pkg::DATA_W;

  logic in_acc;
  logic sat_seen;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // Some component sits at a clamp limit
  assign sat_seen =
    (m_axis_tdata[0*DW +: DW] == vtx_pkg::SAT_MAX) ||
    (m_axis_tdata[0*DW +: DW] == vtx_pkg::SAT_MIN) ||
    (m_axis_tdata[1*DW +: DW] == vtx_pkg::SAT_MAX) ||
    (m_axis_tdata[1*DW +: DW] == vtx_pkg::SAT_MIN) ||
    (m_axis_tdata[2*DW +: DW] == vtx_pkg::SAT_MAX) ||
    (m_axis_tdata[2*DW +: DW] == vtx_pkg::SAT_MIN) ||
    (m_axis_tdata[3*DW +: DW] == vtx_pkg::SAT_MAX) ||
    (m_axis_tdata[3*DW +: DW] == vtx_pkg::SAT_MIN);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // A free output lets every stage advance, so the input is open
  a_flow: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output free");

  // With an idle output and no accepted item in the sampled past, nothing appears
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid && $past(!m_axis_tvalid) && $past(!m_axis_tvalid, 2) &&
    $past(!m_axis_tvalid, 3) && $past(!m_axis_tvalid, 4) &&
    !in_acc && $past(!in_acc) && $past(!in_acc, 2) && $past(!in_acc, 3) &&
    $past(!in_acc, 4) |=> !m_axis_tvalid)
    else $error("result without an accepted item");

  // The saturation flag only comes with a clamped component
  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> sat_seen)
    else $error("saturation flag without a clamped component");

endmodule

bind vertex_transform_4x4_unit vtx_checker u_vtx_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream test of the 4x4 vertex transform. A driver pushes queued vectors into
// the input stream with random gaps, a monitor predicts each transformed
// vector from its own copy of the matrix and checks the output stream in
// order. Between phases the matrix is reloaded over the register port.
// ----------------------------------------------------------------------------
module tb;

  localparam int DATA_W    = vtx_pkg::DATA_W;
  localparam int FRAC_BITS = vtx_pkg::FRAC_BITS;
  localparam int NUM_COMP  = vtx_pkg::NUM_COMP;
  localparam int PROD_W    = vtx_pkg::PROD_W;
  localparam int SUM_W     = vtx_pkg::SUM_W;
  localparam int NUM_REGS  = vtx_pkg::NUM_REGS;
  localparam int REG_W     = vtx_pkg::REG_W;
  localparam int REG_LSB   = vtx_pkg::REG_LSB;
  localparam int ADDR_W    = vtx_pkg::ADDR_W;
  localparam int VEC_W     = vtx_pkg::VEC_W;

  localparam logic [DATA_W-1:0] ONE     = vtx_pkg::ONE;
  localparam logic [DATA_W-1:0] SAT_MAX = vtx_pkg::SAT_MAX;
  localparam logic [DATA_W-1:0] SAT_MIN = vtx_pkg::SAT_MIN;

  localparam int LIMIT = 100000;
  localparam int Q     = 1 << FRAC_BITS;

  // Floored column sums are clamped against these limits
  localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-DATA_W){1'b0}}, SAT_MAX};
  localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-DATA_W){1'b1}}, SAT_MIN};

  typedef struct packed {
    logic              point;
    logic [DATA_W-1:0] w, z, y, x;
  } vertex_t;

  typedef struct {
    logic [DATA_W-1:0] x, y, z, w;
    logic              sat;
  } xform_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  // tdata, low bit up: vec_x, vec_y, vec_z, vec_w
  logic [VEC_W-1:0]  s_tdata  = '0;
  // tuser: point_mode
  logic              s_tuser  = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  // tdata, low bit up: out_x, out_y, out_z, out_w
  logic [VEC_W-1:0]  m_tdata;
  // tuser: saturated
  logic              m_tuser;
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [REG_W-1:0]  pwdata   = '0;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  logic [REG_W-1:0]  mat_q    [NUM_REGS];
  logic [REG_W-1:0]  mat_next [NUM_REGS];
  vertex_t           vertex_queue [$];
  xform_t            vertex_due   [$];
  logic              in_taken = 1'b0;
  logic              calm     = 1'b0;
  int                in_gap   = 0;
  int                out_gap  = 0;
  int                cycles   = 0;
  int                errors   = 0;

  vertex_transform_4x4_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Column j of the output is the exact sum of M[i][j] * v[i], floored and clamped
  function automatic xform_t transform_vertex(vertex_t v);
    logic signed [DATA_W-1:0] comp [NUM_COMP];
    logic signed [DATA_W-1:0] coef;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc;
    logic signed [SUM_W-1:0]  scaled;
    logic [DATA_W-1:0]        res  [NUM_COMP];
    logic [REG_W-1:0]         rg;
    xform_t                   r;
    comp[0] = v.x;
    comp[1] = v.y;
    comp[2] = v.z;
    comp[3] = v.point ? ONE : v.w;
    r.sat   = 1'b0;
    for (int j = 0; j < NUM_COMP; j++) begin
      acc = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
        rg   = mat_q[2 * i + j / 2];
        coef = (j % 2 == 1) ? rg[REG_W-1:DATA_W] : rg[DATA_W-1:0];
        prod = coef * comp[i];
        acc  = acc + prod;
      end
      scaled = acc >>> FRAC_BITS;
      if (scaled > SUM_HI) begin
        res[j] = SAT_MAX;
        r.sat  = 1'b1;
      end else if (scaled < SUM_LO) begin
        res[j] = SAT_MIN;
        r.sat  = 1'b1;
      end else begin
        res[j] = scaled[DATA_W-1:0];
      end
    end
    r.x = res[0];
    r.y = res[1];
    r.z = res[2];
    r.w = res[3];
    return r;
  endfunction

  // A value within +-span, or in wild percent of calls an extreme or any 32-bit pattern
  function automatic logic [DATA_W-1:0] pick_value(int unsigned span, int unsigned wild);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < wild / 4) return SAT_MAX;
    if (roll < wild / 2) return SAT_MIN;
    if (roll < wild) return $urandom;
    return DATA_W'($urandom_range(0, 2 * span)) - DATA_W'(span);
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  task automatic queue_vertex(input logic point,
                              input logic [DATA_W-1:0] x, y, z, w);
    vertex_t v;
    v = '{point: point, w: w, z: z, y: y, x: x};
    vertex_queue.push_back(v);
  endtask

  task automatic apb_write(input int idx, input logic [REG_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx << REG_LSB);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mat_q[idx] = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_matrix();
    for (int r = 0; r < NUM_REGS; r++) apb_write(r, mat_next[r]);
  endtask

  // Hold until every queued vector is accepted and every result has arrived
  task automatic wait_idle();
    while (vertex_queue.size() != 0 || s_tvalid || vertex_due.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Input driver: advance on acceptance, insert idle bursts at random unless calm
  always @(negedge clk) begin : drive_in
    vertex_t nxt;
    if (!s_tvalid || in_taken) begin
      if (in_gap != 0) begin
        in_gap   = in_gap - 1;
        s_tvalid <= 1'b0;
      end else if (vertex_queue.size() != 0 && !calm && $urandom_range(0, 7) == 0) begin
        in_gap   = $urandom_range(0, 7);
        s_tvalid <= 1'b0;
      end else if (vertex_queue.size() != 0) begin
        nxt      = vertex_queue.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.w, nxt.z, nxt.y, nxt.x};
        s_tuser  <= nxt.point;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Output back-pressure in bursts at random, unless calm
  always @(negedge clk) begin : drive_out
    if (out_gap != 0) begin
      out_gap  = out_gap - 1;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap  = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Monitor: check results first, then predict for the item taken this edge
  always @(posedge clk) begin : watch
    vertex_t v;
    xform_t  got;
    xform_t  want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      in_taken <= s_tvalid && s_tready && !rst;
      if (!rst && m_tvalid && m_tready) begin
        got.x   = m_tdata[DATA_W-1:0];
        got.y   = m_tdata[2*DATA_W-1:DATA_W];
        got.z   = m_tdata[3*DATA_W-1:2*DATA_W];
        got.w   = m_tdata[4*DATA_W-1:3*DATA_W];
        got.sat = m_tuser;
        if (vertex_due.size() == 0) begin
          $error("result item with nothing outstanding: %h", m_tdata);
          errors++;
        end else begin
          want = vertex_due.pop_front();
          check_field("out_x", want.x, got.x);
          check_field("out_y", want.y, got.y);
          check_field("out_z", want.z, got.z);
          check_field("out_w", want.w, got.w);
          check_field("saturated", DATA_W'(want.sat), DATA_W'(got.sat));
        end
      end
      if (!rst && s_tvalid && s_tready) begin
        v.x     = s_tdata[DATA_W-1:0];
        v.y     = s_tdata[2*DATA_W-1:DATA_W];
        v.z     = s_tdata[3*DATA_W-1:2*DATA_W];
        v.w     = s_tdata[4*DATA_W-1:3*DATA_W];
        v.point = s_tuser;
        vertex_due.push_back(transform_vertex(v));
      end
    end
  end

  initial begin
    mat_q = vtx_pkg::MAT_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Identity after reset: extremes pass through, point mode ignores w
    queue_vertex(1'b0, '0, '0, '0, '0);
    queue_vertex(1'b0, SAT_MAX, SAT_MIN, '1, ONE);
    queue_vertex(1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    queue_vertex(1'b0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    queue_vertex(1'b1, 3 * Q, -2 * Q, 5, 32'hDEAD_BEEF);
    queue_vertex(1'b1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX);
    wait_idle();

    // Translation in row three: points move, directions do not
    mat_next    = vtx_pkg::MAT_RESET;
    mat_next[6] = {DATA_W'(7 * Q), DATA_W'(-3 * Q)};
    mat_next[7] = {ONE, DATA_W'(-Q / 2)};
    load_matrix();
    queue_vertex(1'b1, Q, 2 * Q, 3 * Q, '0);
    queue_vertex(1'b0, Q, 2 * Q, 3 * Q, '0);
    queue_vertex(1'b1, SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX);
    queue_vertex(1'b0, '0, '0, '0, -2 * Q);
    wait_idle();

    // Largest elements everywhere: overflow both ways
    for (int r = 0; r < NUM_REGS; r++) mat_next[r] = {SAT_MAX, SAT_MAX};
    load_matrix();
    queue_vertex(1'b0, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    queue_vertex(1'b0, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    queue_vertex(1'b0, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MIN);
    queue_vertex(1'b1, SAT_MAX, SAT_MAX, SAT_MAX, '0);
    queue_vertex(1'b0, '0, '0, '0, '0);
    wait_idle();

    // Smallest negative elements: negative sums floor toward minus infinity
    for (int r = 0; r < NUM_REGS; r++) mat_next[r] = '1;
    load_matrix();
    queue_vertex(1'b0, 1, '0, '0, '0);
    queue_vertex(1'b0, '1, '0, '0, '0);
    queue_vertex(1'b0, 1, 1, 1, 1);
    queue_vertex(1'b1, '0, '0, '0, '0);
    queue_vertex(1'b0, Q, '0, '0, '0);
    wait_idle();

    // Random matrices, random vectors; the last phase runs without idling
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) calm = 1'b1;
      for (int r = 0; r < NUM_REGS; r++) begin
        case (ph)
          0:       mat_next[r] = {pick_value(2 * Q, 5), pick_value(2 * Q, 5)};
          1:       mat_next[r] = {pick_value(32'h4000_0000, 100),
                                  pick_value(32'h4000_0000, 100)};
          2:       mat_next[r] = {pick_value(Q, 0), pick_value(Q, 0)};
          default: mat_next[r] = {pick_value(2 * Q, 10), pick_value(2 * Q, 10)};
        endcase
      end
      load_matrix();
      repeat (100)
        queue_vertex(1'($urandom_range(0, 1)), pick_value(8 * Q, 30),
                     pick_value(8 * Q, 30), pick_value(8 * Q, 30),
                     pick_value(8 * Q, 30));
      wait_idle();
    end

    repeat (16) @(posedge clk);
    if (vertex_due.size() != 0) begin
      $error("%0d result items never arrived", vertex_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### vertex_transform_4x4_unit.f
rtl/vtx_pkg.sv
rtl/vertex_transform_4x4_unit.sv
rtl/vtx_checker.sv
test/tb.sv
